@@ hdl/hgnf_pkg.sv @@
// Shared codes, types and helpers for the height grid neighbour filter.
`timescale 1ns / 1ps
`default_nettype none

package hgnf_pkg;

    // Operation codes of the input opcode field
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_IGNORE = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOB  = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH     = 2'd0;
    localparam logic [1:0] CFG_DEPTH     = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;

    // Neighbour directions, in result order; also bit positions of the mask
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic [1:0]         op;
        logic               oob;
        logic [5:0]         x;
        logic [5:0]         y;
        logic [3:0]         nmask;
        logic signed [15:0] hin;
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CENTRE,
        S_NBR,
        S_FINAL
    } t_state;

    // Lowest set direction in a neighbour mask
    function automatic logic [1:0] first_dir(input logic [3:0] m);
        logic [1:0] d;
        d = 2'd0;
        for (int i = 3; i >= 0; i--) begin
            if (m[i]) begin
                d = 2'(i);
            end
        end
        return d;
    endfunction

endpackage

`default_nettype wire

@@ hdl/height_grid_neighbour_filter_top.sv @@
// Items enter the queue at acceptance. The sequencer answers a write or out-of-bounds item
// from idle and a read after its memory read; a query reads the centre, then each in-bounds
// neighbour one read per cycle on the single-port height memory unless a held match waits
// on a stalled output. Results leave through one output register; up to two items wait in
// the command queue. Reset: config returns to 64 x 64 with threshold 0, then a clearing
// pass zeroes all MAX_SIDE * MAX_SIDE cells one cell a cycle with input stalled.
`timescale 1ns / 1ps
`default_nettype none

module height_grid_neighbour_filter_top #(
    parameter int MAX_SIDE    = 64,
    parameter int HEIGHT_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_opcode,
    input  wire logic [5:0]         i_pos_x,
    input  wire logic [5:0]         i_pos_y,
    input  wire logic signed [15:0] i_height_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_status,
    output logic [5:0]              o_cell_x,
    output logic [5:0]              o_cell_y,
    output logic signed [15:0]      o_height_out,
    output logic                    o_last
);

    localparam int CELLS  = MAX_SIDE * MAX_SIDE;
    localparam int AW     = $clog2(CELLS);
    localparam int SW     = $clog2(MAX_SIDE + 1);
    localparam int CW     = (SW > 7) ? SW : 7;
    localparam int DATA_W = $bits(hgnf_pkg::t_cmd) + AW;

    logic [6:0]        r_grid_width;
    logic [6:0]        r_grid_depth;
    logic [15:0]       r_threshold;

    logic [CW-1:0]     eff_width;
    logic              push;
    hgnf_pkg::t_cmd    f_cmd;
    logic [AW-1:0]     f_idx;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    logic [DATA_W-1:0] q_data;
    hgnf_pkg::t_cmd    q_cmd;
    logic [AW-1:0]     q_idx;
    logic              clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width <= 7'd64;
            r_grid_depth <= 7'd64;
            r_threshold  <= 16'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hgnf_pkg::CFG_WIDTH:     r_grid_width <= i_cfg_data[6:0];
                hgnf_pkg::CFG_DEPTH:     r_grid_depth <= i_cfg_data[6:0];
                hgnf_pkg::CFG_THRESHOLD: r_threshold  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // hold input off while the queue is full or the memory is being cleared
    assign o_in_stall = q_full || clearing;

    hgnf_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .i_in_valid   (i_in_valid),
        .i_hold       (o_in_stall),
        .i_opcode     (i_opcode),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_height_in  (i_height_in),
        .i_grid_width (r_grid_width),
        .i_grid_depth (r_grid_depth),
        .o_eff_width  (eff_width),
        .o_push       (push),
        .o_cmd        (f_cmd),
        .o_idx        (f_idx)
    );

    hgnf_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_cmd, f_idx}),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign q_cmd = q_data[DATA_W-1:AW];
    assign q_idx = q_data[AW-1:0];

    hgnf_back #(
        .MAX_SIDE    (MAX_SIDE),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_eff_width  (eff_width),
        .i_threshold  (r_threshold),
        .i_q_valid    (q_valid),
        .i_q_cmd      (q_cmd),
        .i_q_idx      (q_idx),
        .o_q_pop      (q_pop),
        .o_clearing   (clearing),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_cell_x     (o_cell_x),
        .o_cell_y     (o_cell_y),
        .o_height_out (o_height_out),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

@@ hdl/hgnf_front.sv @@
// Front end: accepts input beats, checks bounds and builds the queue entry.
`timescale 1ns / 1ps
`default_nettype none

module hgnf_front #(
    parameter int MAX_SIDE = 64
) (
    input  wire logic                    i_in_valid,
    input  wire logic                    i_hold,
    input  wire logic [1:0]              i_opcode,
    input  wire logic [5:0]              i_pos_x,
    input  wire logic [5:0]              i_pos_y,
    input  wire logic signed [15:0]      i_height_in,
    input  wire logic [6:0]              i_grid_width,
    input  wire logic [6:0]              i_grid_depth,
    output logic [((($clog2(MAX_SIDE + 1)) > 7) ? $clog2(MAX_SIDE + 1) : 7)-1:0] o_eff_width,
    output logic                         o_push,
    output hgnf_pkg::t_cmd               o_cmd,
    output logic [$clog2(MAX_SIDE * MAX_SIDE)-1:0] o_idx
);

    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int CW    = (SW > 7) ? SW : 7;
    localparam int PW    = CW + 7;

    logic [CW-1:0] eff_w;
    logic [CW-1:0] eff_d;
    logic [CW-1:0] x_ext;
    logic [CW-1:0] y_ext;
    logic [PW-1:0] lin;

    always_comb begin
        // geometry above the store size acts as the store size
        eff_w = (CW'(i_grid_width) > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : CW'(i_grid_width);
        eff_d = (CW'(i_grid_depth) > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : CW'(i_grid_depth);
        x_ext = CW'(i_pos_x);
        y_ext = CW'(i_pos_y);
        lin   = PW'(i_pos_y) * PW'(eff_w) + PW'(i_pos_x);

        o_cmd.op    = i_opcode;
        o_cmd.oob   = !((x_ext < eff_w) && (y_ext < eff_d));
        o_cmd.x     = i_pos_x;
        o_cmd.y     = i_pos_y;
        o_cmd.hin   = i_height_in;
        o_cmd.nmask[hgnf_pkg::DIR_UP]    = (y_ext + CW'(1)) < eff_d;
        o_cmd.nmask[hgnf_pkg::DIR_DOWN]  = (i_pos_y != 6'd0);
        o_cmd.nmask[hgnf_pkg::DIR_RIGHT] = (x_ext + CW'(1)) < eff_w;
        o_cmd.nmask[hgnf_pkg::DIR_LEFT]  = (i_pos_x != 6'd0);

        o_idx       = AW'(lin);
        o_eff_width = eff_w;
        // drop unused opcodes at the door
        o_push = i_in_valid && !i_hold && (i_opcode != hgnf_pkg::OP_IGNORE);
    end

endmodule

`default_nettype wire

@@ hdl/hgnf_queue.sv @@
// Short command queue between the front end and the memory sequencer.
`timescale 1ns / 1ps
`default_nettype none

module hgnf_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_data
);

    localparam int PTRW = (hgnf_pkg::Q_DEPTH > 1) ? $clog2(hgnf_pkg::Q_DEPTH) : 1;
    localparam int CNTW = $clog2(hgnf_pkg::Q_DEPTH + 1);

    logic [DATA_W-1:0] r_slot [hgnf_pkg::Q_DEPTH];
    logic [PTRW-1:0]   r_wr;
    logic [PTRW-1:0]   r_rd;
    logic [CNTW-1:0]   r_cnt;
    logic [PTRW-1:0]   n_wr;
    logic [PTRW-1:0]   n_rd;
    logic [CNTW-1:0]   n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTRW'(hgnf_pkg::Q_DEPTH - 1)) ? '0 : r_wr + PTRW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTRW'(hgnf_pkg::Q_DEPTH - 1)) ? '0 : r_rd + PTRW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNTW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

    assign o_full  = (r_cnt == CNTW'(hgnf_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_slot[r_rd];

endmodule

`default_nettype wire

@@ hdl/hgnf_back.sv @@
// Back end: height memory, clearing pass, neighbour sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none

module hgnf_back #(
    parameter int MAX_SIDE    = 64,
    parameter int HEIGHT_BITS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [((($clog2(MAX_SIDE + 1)) > 7) ? $clog2(MAX_SIDE + 1) : 7)-1:0] i_eff_width,
    input  wire logic [15:0]             i_threshold,
    input  wire logic                    i_q_valid,
    input  wire hgnf_pkg::t_cmd          i_q_cmd,
    input  wire logic [$clog2(MAX_SIDE * MAX_SIDE)-1:0] i_q_idx,
    output logic                         o_q_pop,
    output logic                         o_clearing,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [1:0]                   o_status,
    output logic [5:0]                   o_cell_x,
    output logic [5:0]                   o_cell_y,
    output logic signed [15:0]           o_height_out,
    output logic                         o_last
);

    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int HB    = HEIGHT_BITS;
    localparam int CMPW  = (HB + 1 > 16) ? HB + 1 : 16;

    // height memory, single port, registered read
    logic signed [HB-1:0] r_mem [CELLS];
    logic signed [HB-1:0] r_rdata;
    logic                 mem_we;
    logic                 mem_re;
    logic [AW-1:0]        mem_addr;
    logic signed [HB-1:0] mem_wdata;

    hgnf_pkg::t_state     r_state, n_state;
    hgnf_pkg::t_cmd       r_cmd, n_cmd;
    logic [AW-1:0]        r_idx, n_idx;
    logic signed [HB-1:0] r_hc, n_hc;
    logic [1:0]           r_dir, n_dir;
    logic [3:0]           r_rem, n_rem;
    logic                 r_pend_valid, n_pend_valid;
    logic [5:0]           r_pend_x, n_pend_x;
    logic [5:0]           r_pend_y, n_pend_y;
    logic signed [HB-1:0] r_pend_h, n_pend_h;
    logic [AW-1:0]        r_clr, n_clr;

    logic                 r_out_valid, n_out_valid;
    logic [1:0]           r_out_status, n_out_status;
    logic [5:0]           r_out_x, n_out_x;
    logic [5:0]           r_out_y, n_out_y;
    logic signed [15:0]   r_out_h, n_out_h;
    logic                 r_out_last, n_out_last;

    logic                 out_free;
    logic                 emit;
    logic [1:0]           e_status;
    logic [5:0]           e_x;
    logic [5:0]           e_y;
    logic signed [15:0]   e_h;
    logic                 e_last;

    logic signed [HB-1:0] hsat;
    logic [1:0]           a_dir;
    logic [AW-1:0]        w_a;
    logic [AW-1:0]        nbr_addr;
    logic [5:0]           cur_x;
    logic [5:0]           cur_y;
    logic signed [HB:0]   diff;
    logic [HB:0]          absd;
    logic                 pass;
    logic [1:0]           nxt_dir;

    // saturate or sign-extend the written height to the stored width
    generate
        if (HB < 16) begin : g_sat
            localparam logic signed [15:0] HI = 16'((2 ** (HB - 1)) - 1);
            localparam logic signed [15:0] LO = ~HI;
            always_comb begin
                if (i_q_cmd.hin > HI) begin
                    hsat = HB'(HI);
                end else if (i_q_cmd.hin < LO) begin
                    hsat = HB'(LO);
                end else begin
                    hsat = HB'(i_q_cmd.hin);
                end
            end
        end else begin : g_ext
            assign hsat = HB'(i_q_cmd.hin);
        end
    endgenerate

    always_comb begin
        w_a = AW'(i_eff_width);
        unique case (a_dir)
            hgnf_pkg::DIR_UP:    nbr_addr = r_idx + w_a;
            hgnf_pkg::DIR_DOWN:  nbr_addr = r_idx - w_a;
            hgnf_pkg::DIR_RIGHT: nbr_addr = r_idx + AW'(1);
            hgnf_pkg::DIR_LEFT:  nbr_addr = r_idx - AW'(1);
        endcase

        cur_x = r_cmd.x;
        cur_y = r_cmd.y;
        unique case (r_dir)
            hgnf_pkg::DIR_UP:    cur_y = r_cmd.y + 6'd1;
            hgnf_pkg::DIR_DOWN:  cur_y = r_cmd.y - 6'd1;
            hgnf_pkg::DIR_RIGHT: cur_x = r_cmd.x + 6'd1;
            hgnf_pkg::DIR_LEFT:  cur_x = r_cmd.x - 6'd1;
        endcase

        diff = {r_hc[HB-1], r_hc} - {r_rdata[HB-1], r_rdata};
        absd = diff[HB] ? (HB + 1)'(-diff) : (HB + 1)'(diff);
        pass = CMPW'(absd) <= CMPW'(i_threshold);
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_idx        = r_idx;
        n_hc         = r_hc;
        n_dir        = r_dir;
        n_rem        = r_rem;
        n_pend_valid = r_pend_valid;
        n_pend_x     = r_pend_x;
        n_pend_y     = r_pend_y;
        n_pend_h     = r_pend_h;
        n_clr        = r_clr;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_addr     = r_idx;
        mem_wdata    = '0;
        a_dir        = hgnf_pkg::DIR_UP;
        o_q_pop      = 1'b0;
        emit         = 1'b0;
        e_status     = hgnf_pkg::ST_OK;
        e_x          = r_cmd.x;
        e_y          = r_cmd.y;
        e_h          = '0;
        e_last       = 1'b1;
        nxt_dir      = hgnf_pkg::first_dir(r_rem);

        unique case (r_state)
            hgnf_pkg::S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr;
                n_clr    = r_clr + AW'(1);
                if (r_clr == AW'(CELLS - 1)) begin
                    n_state = hgnf_pkg::S_IDLE;
                end
            end
            hgnf_pkg::S_IDLE: begin
                mem_addr = i_q_idx;
                e_x      = i_q_cmd.x;
                e_y      = i_q_cmd.y;
                if (i_q_valid) begin
                    if (i_q_cmd.oob) begin
                        if (out_free) begin
                            o_q_pop  = 1'b1;
                            emit     = 1'b1;
                            e_status = hgnf_pkg::ST_OOB;
                        end
                    end else if (i_q_cmd.op == hgnf_pkg::OP_WRITE) begin
                        if (out_free) begin
                            o_q_pop   = 1'b1;
                            mem_we    = 1'b1;
                            mem_wdata = hsat;
                            emit      = 1'b1;
                            e_h       = 16'(hsat);
                        end
                    end else begin
                        o_q_pop = 1'b1;
                        mem_re  = 1'b1;
                        n_cmd   = i_q_cmd;
                        n_idx   = i_q_idx;
                        n_state = (i_q_cmd.op == hgnf_pkg::OP_READ) ?
                                  hgnf_pkg::S_READ : hgnf_pkg::S_CENTRE;
                    end
                end
            end
            hgnf_pkg::S_READ: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_h     = 16'(r_rdata);
                    n_state = hgnf_pkg::S_IDLE;
                end
            end
            hgnf_pkg::S_CENTRE: begin
                n_hc         = r_rdata;
                n_pend_valid = 1'b0;
                if (r_cmd.nmask == 4'd0) begin
                    n_state = hgnf_pkg::S_FINAL;
                end else begin
                    a_dir    = hgnf_pkg::first_dir(r_cmd.nmask);
                    mem_re   = 1'b1;
                    mem_addr = nbr_addr;
                    n_dir    = a_dir;
                    n_rem    = r_cmd.nmask & ~(4'd1 << a_dir);
                    n_state  = hgnf_pkg::S_NBR;
                end
            end
            hgnf_pkg::S_NBR: begin
                // hold the read data while an earlier match waits for the output
                if (!(pass && r_pend_valid && !out_free)) begin
                    if (pass && r_pend_valid) begin
                        emit   = 1'b1;
                        e_x    = r_pend_x;
                        e_y    = r_pend_y;
                        e_h    = 16'(r_pend_h);
                        e_last = 1'b0;
                    end
                    if (pass) begin
                        n_pend_valid = 1'b1;
                        n_pend_x     = cur_x;
                        n_pend_y     = cur_y;
                        n_pend_h     = r_rdata;
                    end
                    if (r_rem != 4'd0) begin
                        a_dir    = nxt_dir;
                        mem_re   = 1'b1;
                        mem_addr = nbr_addr;
                        n_dir    = nxt_dir;
                        n_rem    = r_rem & ~(4'd1 << nxt_dir);
                    end else begin
                        n_state = hgnf_pkg::S_FINAL;
                    end
                end
            end
            hgnf_pkg::S_FINAL: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = hgnf_pkg::S_IDLE;
                    if (r_pend_valid) begin
                        e_x = r_pend_x;
                        e_y = r_pend_y;
                        e_h = 16'(r_pend_h);
                    end else begin
                        e_status = hgnf_pkg::ST_NONE;
                        e_h      = 16'(r_hc);
                    end
                end
            end
            default: begin
                n_state = hgnf_pkg::S_IDLE;
            end
        endcase

        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_h      = r_out_h;
        n_out_last   = r_out_last;
        if (emit) begin
            n_out_valid  = 1'b1;
            n_out_status = e_status;
            n_out_x      = e_x;
            n_out_y      = e_y;
            n_out_h      = e_h;
            n_out_last   = e_last;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= hgnf_pkg::S_CLEAR;
            r_clr        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_idx        <= n_idx;
        r_hc         <= n_hc;
        r_dir        <= n_dir;
        r_rem        <= n_rem;
        r_pend_x     <= n_pend_x;
        r_pend_y     <= n_pend_y;
        r_pend_h     <= n_pend_h;
        r_out_status <= n_out_status;
        r_out_x      <= n_out_x;
        r_out_y      <= n_out_y;
        r_out_h      <= n_out_h;
        r_out_last   <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    assign o_clearing   = (r_state == hgnf_pkg::S_CLEAR);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_cell_x     = r_out_x;
    assign o_cell_y     = r_out_y;
    assign o_height_out = r_out_h;
    assign o_last       = r_out_last;

endmodule

`default_nettype wire

@@ test/hgnf_checker.sv @@
// Checker: mirrors the height grid, predicts every result beat and compares it.
`timescale 1ns / 1ps

module hgnf_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire logic [1:0]         i_opcode,
    input  wire logic [5:0]         i_pos_x,
    input  wire logic [5:0]         i_pos_y,
    input  wire logic signed [15:0] i_height_in,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic [1:0]         i_status,
    input  wire logic [5:0]         i_cell_x,
    input  wire logic [5:0]         i_cell_y,
    input  wire logic signed [15:0] i_height_out,
    input  wire logic               i_last,
    output int                      o_fail_count,
    output int                      o_pending
);

    localparam int SIDE       = 64;
    localparam int CELLS      = SIDE * SIDE;

    // Neighbour steps in result order: up, down, right, left
    localparam int STEP_X [4] = '{0, 0, 1, -1};
    localparam int STEP_Y [4] = '{1, -1, 0, 0};

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         x;
        logic [5:0]         y;
        logic signed [15:0] height;
        logic               last;
    } grid_result_t;

    logic [6:0]         cols;
    logic [6:0]         rows;
    logic [15:0]        diff_limit;
    logic signed [15:0] heights [0:CELLS-1];
    grid_result_t       results_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Sizes above the store side act as the full side
    function automatic int side_of(input logic [6:0] v);
        return (int'(v) > SIDE) ? SIDE : int'(v);
    endfunction

    function automatic bit on_grid(input int x, input int y);
        return x >= 0 && y >= 0 && x < side_of(cols) && y < side_of(rows);
    endfunction

    function automatic int cell_addr(input int x, input int y);
        int idx;
        idx = y * side_of(cols) + x;
        return (idx < CELLS) ? idx : 0;
    endfunction

    task automatic report_mismatch(input string what);
        o_fail_count++;
        $display("%0t hgnf_checker: %s", $time, what);
    endtask

    task automatic predict_beat(input logic [1:0] op, input logic [5:0] px,
                                input logic [5:0] py, input logic signed [15:0] hin);
        int                 cx;
        int                 cy;
        int                 nx;
        int                 ny;
        int                 diff;
        int                 found;
        logic signed [15:0] centre;
        logic signed [15:0] nbr;
        grid_result_t       r;
        cx    = int'(px);
        cy    = int'(py);
        found = 0;
        if (op == hgnf_pkg::OP_IGNORE) begin
            // no result for the unused code
        end else if (!on_grid(cx, cy)) begin
            results_q.push_back('{hgnf_pkg::ST_OOB, px, py, 16'sd0, 1'b1});
        end else if (op == hgnf_pkg::OP_WRITE) begin
            heights[cell_addr(cx, cy)] = hin;
            results_q.push_back('{hgnf_pkg::ST_OK, px, py, hin, 1'b1});
        end else begin
            centre = heights[cell_addr(cx, cy)];
            if (op == hgnf_pkg::OP_READ) begin
                results_q.push_back('{hgnf_pkg::ST_OK, px, py, centre, 1'b1});
            end else begin
                for (int d = 0; d < 4; d++) begin
                    nx = cx + STEP_X[d];
                    ny = cy + STEP_Y[d];
                    if (on_grid(nx, ny)) begin
                        nbr  = heights[cell_addr(nx, ny)];
                        diff = int'(centre) - int'(nbr);
                        if (diff < 0) begin
                            diff = -diff;
                        end
                        if (diff <= int'(diff_limit)) begin
                            results_q.push_back('{hgnf_pkg::ST_OK, 6'(nx), 6'(ny), nbr, 1'b0});
                            found++;
                        end
                    end
                end
                if (found == 0) begin
                    results_q.push_back('{hgnf_pkg::ST_NONE, px, py, centre, 1'b1});
                end else begin
                    // mark the final neighbour of this query
                    r      = results_q.pop_back();
                    r.last = 1'b1;
                    results_q.push_back(r);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        grid_result_t want;
        if (!i_rst_n) begin
            cols       = 7'd64;
            rows       = 7'd64;
            diff_limit = 16'd0;
            foreach (heights[i]) begin
                heights[i] = 16'sd0;
            end
            results_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (results_q.size() == 0) begin
                    report_mismatch($sformatf("result beat (%0d,%0d) with none expected",
                                              i_cell_x, i_cell_y));
                end else begin
                    want = results_q.pop_front();
                    if (i_status !== want.status) begin
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  i_status, want.status));
                    end
                    if (i_cell_x !== want.x) begin
                        report_mismatch($sformatf("cell_x got %0d want %0d", i_cell_x, want.x));
                    end
                    if (i_cell_y !== want.y) begin
                        report_mismatch($sformatf("cell_y got %0d want %0d", i_cell_y, want.y));
                    end
                    if (i_height_out !== want.height) begin
                        report_mismatch($sformatf("height_out got %h want %h at (%0d,%0d)",
                                                  i_height_out, want.height, want.x, want.y));
                    end
                    if (i_last !== want.last) begin
                        report_mismatch($sformatf("last got %b want %b at (%0d,%0d)",
                                                  i_last, want.last, want.x, want.y));
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    hgnf_pkg::CFG_WIDTH:     cols       = i_cfg_data[6:0];
                    hgnf_pkg::CFG_DEPTH:     rows       = i_cfg_data[6:0];
                    hgnf_pkg::CFG_THRESHOLD: diff_limit = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict_beat(i_opcode, i_pos_x, i_pos_y, i_height_in);
            end
        end
        o_pending = results_q.size();
    end

endmodule

@@ test/tb_height_grid_neighbour_filter_top.sv @@
// Testbench top: drives the height grid filter with directed and random beats and reports.
`timescale 1ns / 1ps

module tb_height_grid_neighbour_filter_top;

    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 120;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 36;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               cfg_we     = 1'b0;
    logic [1:0]         cfg_index  = hgnf_pkg::CFG_WIDTH;
    logic [15:0]        cfg_data   = 16'd0;
    logic               in_valid   = 1'b0;
    logic [1:0]         opcode     = hgnf_pkg::OP_READ;
    logic [5:0]         pos_x      = 6'd0;
    logic [5:0]         pos_y      = 6'd0;
    logic signed [15:0] height_in  = 16'sd0;
    logic               out_stall  = 1'b0;
    wire                in_stall;
    wire                out_valid;
    wire  [1:0]         status;
    wire  [5:0]         cell_x;
    wire  [5:0]         cell_y;
    wire  signed [15:0] height_out;
    wire                last;
    int                 fail_count;
    int                 expected_left;

    // gaps_on and hold_len are shared with the result-side process
    bit                 gaps_on  = 1'b1;
    int                 hold_len = 0;
    logic [6:0]         cur_cols = 7'd64;
    logic [6:0]         cur_rows = 7'd64;

    always #10 clk = ~clk;

    height_grid_neighbour_filter_top u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_opcode     (opcode),
        .i_pos_x      (pos_x),
        .i_pos_y      (pos_y),
        .i_height_in  (height_in),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_status     (status),
        .o_cell_x     (cell_x),
        .o_cell_y     (cell_y),
        .o_height_out (height_out),
        .o_last       (last)
    );

    hgnf_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_opcode     (opcode),
        .i_pos_x      (pos_x),
        .i_pos_y      (pos_y),
        .i_height_in  (height_in),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_status     (status),
        .i_cell_x     (cell_x),
        .i_cell_y     (cell_y),
        .i_height_out (height_out),
        .i_last       (last),
        .o_fail_count (fail_count),
        .o_pending    (expected_left)
    );

    function automatic int usable(input logic [6:0] v);
        return (int'(v) > 64) ? 64 : int'(v);
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [5:0] x, input logic [5:0] y,
                             input logic signed [15:0] h);
        int gap;
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        pos_x     <= x;
        pos_y     <= y;
        height_in <= h;
        do @(posedge clk); while (in_stall);
    endtask

    // Drop valid and hold until every expected beat is back, then let the pipe empty
    task automatic settle(input int drain);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (expected_left == 0);
        repeat (drain) @(posedge clk);
    endtask

    task automatic set_register(input logic [1:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic configure(input logic [6:0] w, input logic [6:0] d, input logic [15:0] th);
        settle(DRAIN_CYCLES);
        set_register(hgnf_pkg::CFG_WIDTH, 16'(w));
        set_register(hgnf_pkg::CFG_DEPTH, 16'(d));
        set_register(hgnf_pkg::CFG_THRESHOLD, th);
        cur_cols = w;
        cur_rows = d;
    endtask

    // Result side: random stall before each beat while gaps are on, plus one long hold on request
    initial begin
        int n;
        forever begin
            if (hold_len > 0) begin
                out_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end
            n = gaps_on ? $urandom_range(0, 5) : 0;
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        #5_000_000;
        $display("tb_height_grid_neighbour_filter_top: FAIL");
        $finish;
    end

    initial begin
        int                 sent;
        int                 ew;
        int                 er;
        int                 pick;
        logic [1:0]         op;
        logic [5:0]         x;
        logic [5:0]         y;
        logic signed [15:0] h;
        logic signed [15:0] base;
        logic [6:0]         w;
        logic [6:0]         d;
        logic [15:0]        th;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset geometry 64 x 64, threshold zero: cleared store, edges and corners
        send_item(hgnf_pkg::OP_READ,   6'd0,  6'd0,  16'sd0);
        send_item(hgnf_pkg::OP_QUERY,  6'd0,  6'd0,  16'sd0);
        send_item(hgnf_pkg::OP_WRITE,  6'd63, 6'd63, 16'sh7FFF);
        send_item(hgnf_pkg::OP_WRITE,  6'd0,  6'd0,  16'sh8000);
        send_item(hgnf_pkg::OP_WRITE,  6'd5,  6'd5,  16'sh0100);
        send_item(hgnf_pkg::OP_WRITE,  6'd5,  6'd6,  16'sh0100);
        send_item(hgnf_pkg::OP_WRITE,  6'd5,  6'd4,  16'sh0180);
        send_item(hgnf_pkg::OP_READ,   6'd63, 6'd63, 16'sd0);
        send_item(hgnf_pkg::OP_READ,   6'd0,  6'd0,  16'sd0);
        send_item(hgnf_pkg::OP_QUERY,  6'd63, 6'd63, 16'sd0);
        send_item(hgnf_pkg::OP_QUERY,  6'd5,  6'd5,  16'sd0);
        send_item(hgnf_pkg::OP_IGNORE, 6'd63, 6'd63, 16'shFFFF);

        // Narrow grid, widest threshold: full swing difference, all four neighbours,
        // corner query and positions past the limits
        configure(7'd10, 7'd7, 16'hFFFF);
        send_item(hgnf_pkg::OP_WRITE, 6'd1,  6'd0,  16'sh7FFF);
        send_item(hgnf_pkg::OP_QUERY, 6'd0,  6'd0,  16'sd0);
        send_item(hgnf_pkg::OP_QUERY, 6'd5,  6'd5,  16'sd0);
        send_item(hgnf_pkg::OP_QUERY, 6'd9,  6'd6,  16'sd0);
        send_item(hgnf_pkg::OP_READ,  6'd10, 6'd0,  16'sd0);
        send_item(hgnf_pkg::OP_WRITE, 6'd0,  6'd7,  16'sh1234);
        send_item(hgnf_pkg::OP_QUERY, 6'd63, 6'd63, 16'sd0);

        // Zero width: everything is off the grid; oversized depth
        configure(7'd0, 7'd127, 16'd0);
        send_item(hgnf_pkg::OP_WRITE, 6'd0, 6'd0, 16'sh5555);
        send_item(hgnf_pkg::OP_READ,  6'd0, 6'd0, 16'sd0);
        send_item(hgnf_pkg::OP_QUERY, 6'd0, 6'd0, 16'sd0);

        // Single cell: a query has no neighbour at all
        configure(7'd1, 7'd1, 16'd0);
        send_item(hgnf_pkg::OP_QUERY, 6'd0, 6'd0, 16'sd0);
        send_item(hgnf_pkg::OP_READ,  6'd0, 6'd0, 16'sd0);

        // Oversized width acts as 64 on a single row
        configure(7'd127, 7'd1, 16'h0080);
        send_item(hgnf_pkg::OP_QUERY, 6'd63, 6'd0, 16'sd0);
        send_item(hgnf_pkg::OP_QUERY, 6'd0,  6'd0, 16'sd0);

        for (int phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(0, 5))
                0:       w = 7'd1;
                1:       w = 7'd64;
                2:       w = 7'($urandom_range(65, 127));
                default: w = 7'($urandom_range(2, 12));
            endcase
            case ($urandom_range(0, 5))
                0:       d = 7'd1;
                1:       d = 7'd64;
                2:       d = 7'($urandom_range(65, 127));
                default: d = 7'($urandom_range(2, 12));
            endcase
            case ($urandom_range(0, 3))
                0:       th = 16'd0;
                1:       th = 16'($urandom_range(1, 512));
                2:       th = 16'($urandom);
                default: th = 16'hFFFF;
            endcase
            configure(w, d, th);
            base    = 16'($urandom);
            gaps_on = (phase != 2);
            if (phase == 4) begin
                // fill the block against a stalled output
                hold_len = HOLD_CYCLES;
            end
            ew   = usable(cur_cols);
            er   = usable(cur_rows);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    op = hgnf_pkg::OP_WRITE;
                end else if (pick < 55) begin
                    op = hgnf_pkg::OP_READ;
                end else if (pick < 95) begin
                    op = hgnf_pkg::OP_QUERY;
                end else begin
                    op = hgnf_pkg::OP_IGNORE;
                end
                if (ew > 0 && er > 0 && $urandom_range(0, 9) != 0) begin
                    x = 6'($urandom_range(0, ew - 1));
                    y = 6'($urandom_range(0, er - 1));
                end else begin
                    x = 6'($urandom);
                    y = 6'($urandom);
                end
                // keep about half the heights near a common level so thresholds bite
                if ($urandom_range(0, 1) == 0) begin
                    h = 16'($urandom);
                end else begin
                    h = base + 16'($urandom_range(0, 511)) - 16'd256;
                end
                send_item(op, x, y, h);
                if (op != hgnf_pkg::OP_IGNORE) begin
                    sent++;
                end
                if (phase == 6 && sent == PHASE_ITEMS / 2) begin
                    settle(0);
                end
            end
        end

        settle(DRAIN_CYCLES);
        if (fail_count == 0) begin
            $display("tb_height_grid_neighbour_filter_top: PASS");
        end else begin
            $display("tb_height_grid_neighbour_filter_top: FAIL");
        end
        $finish;
    end

endmodule
